// File: rtl/query_text_tokenizer_defines.svh
// Assertion macros for the tokenizer; sampled on clk, disabled while arst_n is low.
`ifndef QUERY_TEXT_TOKENIZER_DEFINES_SVH
`define QUERY_TEXT_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS

`define QTT_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer assertion failed");

`define QTT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer assertion failed");

`else

`define QTT_ASSERT_IMPLY(lbl, ante, cons)
`define QTT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/qtt_pkg.sv
package qtt_pkg;

	localparam int unsigned MAX_RESULTS = 4;

	typedef enum logic [3:0] {
		K_EMPTY  = 4'd0,
		K_IDENT  = 4'd1,
		K_AND    = 4'd2,
		K_OR     = 4'd3,
		K_NUMBER = 4'd4,
		K_STRING = 4'd5,
		K_LPAREN = 4'd6,
		K_RPAREN = 4'd7,
		K_EQ     = 4'd8,
		K_NE     = 4'd9,
		K_LT     = 4'd10,
		K_LE     = 4'd11,
		K_GT     = 4'd12,
		K_GE     = 4'd13
	} qtt_kind_t;

	typedef struct packed {
		qtt_kind_t  kind;
		logic [7:0] text_byte;
		logic       is_text;
		logic       source_end;
	} qtt_result_t;

	// all results caused by one character, oldest in entry 0
	typedef struct packed {
		qtt_result_t [MAX_RESULTS-1:0] res;
		logic [2:0]                    n;
	} qtt_batch_t;

endpackage

// File: rtl/qtt_lexer.sv
module qtt_lexer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         ch,
	input  logic               last,
	output qtt_pkg::qtt_batch_t batch
);

	typedef enum logic [1:0] {
		M_IDLE   = 2'd0,
		M_IDENT  = 2'd1,
		M_NUMBER = 2'd2,
		M_STRING = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		P_NONE = 3'd0,
		P_EQ   = 3'd1,
		P_BANG = 3'd2,
		P_LT   = 3'd3,
		P_GT   = 3'd4
	} pend_t;

	typedef enum logic [2:0] {
		KW_NONE = 3'd0,
		KW_A    = 3'd1,
		KW_AN   = 3'd2,
		KW_AND  = 3'd3,
		KW_O    = 3'd4,
		KW_OR   = 3'd5
	} kw_t;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_DIG0    = 8'h30;
	localparam logic [7:0] CH_DIG9    = 8'h39;
	localparam logic [7:0] CH_LT      = 8'h3C;
	localparam logic [7:0] CH_EQ      = 8'h3D;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_Z    = 8'h5A;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_USCORE  = 8'h5F;
	localparam logic [7:0] CH_LO_A    = 8'h61;
	localparam logic [7:0] CH_LO_D    = 8'h64;
	localparam logic [7:0] CH_LO_N    = 8'h6E;
	localparam logic [7:0] CH_LO_O    = 8'h6F;
	localparam logic [7:0] CH_LO_R    = 8'h72;
	localparam logic [7:0] CH_LO_T    = 8'h74;
	localparam logic [7:0] CH_LO_Z    = 8'h7A;

	function automatic qtt_pkg::qtt_result_t mk(qtt_pkg::qtt_kind_t k, logic [7:0] b,
			logic txt, logic send);
		qtt_pkg::qtt_result_t r;
		r.kind       = k;
		r.text_byte  = b;
		r.is_text    = txt;
		r.source_end = send;
		return r;
	endfunction

	function automatic qtt_pkg::qtt_kind_t op_with_eq(pend_t p);
		qtt_pkg::qtt_kind_t k;
		unique case (p)
			P_EQ:    k = qtt_pkg::K_EQ;
			P_BANG:  k = qtt_pkg::K_NE;
			P_LT:    k = qtt_pkg::K_LE;
			P_GT:    k = qtt_pkg::K_GE;
			default: k = qtt_pkg::K_EMPTY;
		endcase
		return k;
	endfunction

	function automatic qtt_pkg::qtt_kind_t op_alone(pend_t p);
		qtt_pkg::qtt_kind_t k;
		unique case (p)
			P_LT:    k = qtt_pkg::K_LT;
			P_GT:    k = qtt_pkg::K_GT;
			default: k = qtt_pkg::K_EMPTY;
		endcase
		return k;
	endfunction

	function automatic kw_t kw_next(kw_t p, logic [7:0] c);
		kw_t k;
		if (p == KW_A && c == CH_LO_N)
			k = KW_AN;
		else if (p == KW_AN && c == CH_LO_D)
			k = KW_AND;
		else if (p == KW_O && c == CH_LO_R)
			k = KW_OR;
		else
			k = KW_NONE;
		return k;
	endfunction

	mode_t mode_q, mode_d;
	pend_t pend_q, pend_d;
	kw_t   kw_q, kw_d;
	logic  dquote_q, dquote_d;
	logic  esc_q, esc_d;
	logic  ended_q, ended_d;

	logic       go;
	logic       is_letter, is_digit, is_space;
	logic [7:0] esc_byte;
	logic [2:0] n;
	qtt_pkg::qtt_result_t [qtt_pkg::MAX_RESULTS-1:0] res;

	assign is_letter = (ch >= CH_UP_A && ch <= CH_UP_Z) || (ch >= CH_LO_A && ch <= CH_LO_Z);
	assign is_digit  = ch >= CH_DIG0 && ch <= CH_DIG9;
	assign is_space  = ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
	assign esc_byte  = (ch == CH_LO_N) ? CH_LF : ((ch == CH_LO_T) ? CH_TAB : ch);

	always_comb begin
		mode_d   = mode_q;
		pend_d   = pend_q;
		kw_d     = kw_q;
		dquote_d = dquote_q;
		esc_d    = esc_q;
		ended_d  = ended_q;
		go       = 1'b0;
		n        = 3'd0;
		res      = '0;

		if (ended_q) begin
			// swallow the rest of a source cut short by NUL
			if (last)
				ended_d = 1'b0;
		end else begin
			if (ch != CH_NUL) begin
				go = 1'b1;
				// operator lookahead
				if (pend_d != P_NONE) begin
					if (ch == CH_EQ) begin
						res[n[1:0]] = mk(op_with_eq(pend_d), 8'h00, 1'b0, 1'b0);
						n = n + 3'd1;
						go = 1'b0;
					end else begin
						res[n[1:0]] = mk(op_alone(pend_d), 8'h00, 1'b0, 1'b0);
						n = n + 3'd1;
					end
					pend_d = P_NONE;
				end
				if (go && mode_d == M_IDENT) begin
					if (is_letter || is_digit || ch == CH_USCORE || ch == CH_DOT) begin
						res[n[1:0]] = mk(qtt_pkg::K_IDENT, ch, 1'b1, 1'b0);
						n = n + 3'd1;
						kw_d = kw_next(kw_d, ch);
						go = 1'b0;
					end else begin
						res[n[1:0]] = mk((kw_d == KW_AND) ? qtt_pkg::K_AND :
							((kw_d == KW_OR) ? qtt_pkg::K_OR : qtt_pkg::K_IDENT),
							8'h00, 1'b0, 1'b0);
						n = n + 3'd1;
						mode_d = M_IDLE;
						kw_d = KW_NONE;
						dquote_d = 1'b0;
						esc_d = 1'b0;
					end
				end else if (go && mode_d == M_NUMBER) begin
					if (is_digit || ch == CH_DOT) begin
						res[n[1:0]] = mk(qtt_pkg::K_NUMBER, ch, 1'b1, 1'b0);
						n = n + 3'd1;
						go = 1'b0;
					end else begin
						res[n[1:0]] = mk(qtt_pkg::K_NUMBER, 8'h00, 1'b0, 1'b0);
						n = n + 3'd1;
						mode_d = M_IDLE;
						kw_d = KW_NONE;
						dquote_d = 1'b0;
						esc_d = 1'b0;
					end
				end else if (go && mode_d == M_STRING) begin
					go = 1'b0;
					if (esc_d) begin
						res[n[1:0]] = mk(qtt_pkg::K_STRING, esc_byte, 1'b1, 1'b0);
						n = n + 3'd1;
						esc_d = 1'b0;
					end else if (ch == (dquote_d ? CH_DQUOTE : CH_SQUOTE)) begin
						res[n[1:0]] = mk(qtt_pkg::K_STRING, 8'h00, 1'b0, 1'b0);
						n = n + 3'd1;
						mode_d = M_IDLE;
						kw_d = KW_NONE;
						dquote_d = 1'b0;
					end else if (ch == CH_BSLASH) begin
						esc_d = 1'b1;
					end else begin
						res[n[1:0]] = mk(qtt_pkg::K_STRING, ch, 1'b1, 1'b0);
						n = n + 3'd1;
					end
				end
				// between tokens
				if (go) begin
					if (is_space) begin
						mode_d = M_IDLE;
					end else if (is_letter || ch == CH_USCORE) begin
						mode_d = M_IDENT;
						kw_d = (ch == CH_LO_A) ? KW_A : ((ch == CH_LO_O) ? KW_O : KW_NONE);
						res[n[1:0]] = mk(qtt_pkg::K_IDENT, ch, 1'b1, 1'b0);
						n = n + 3'd1;
					end else if (is_digit) begin
						mode_d = M_NUMBER;
						res[n[1:0]] = mk(qtt_pkg::K_NUMBER, ch, 1'b1, 1'b0);
						n = n + 3'd1;
					end else if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
						mode_d = M_STRING;
						dquote_d = ch == CH_DQUOTE;
						esc_d = 1'b0;
					end else if (ch == CH_LPAREN) begin
						res[n[1:0]] = mk(qtt_pkg::K_LPAREN, 8'h00, 1'b0, 1'b0);
						n = n + 3'd1;
					end else if (ch == CH_RPAREN) begin
						res[n[1:0]] = mk(qtt_pkg::K_RPAREN, 8'h00, 1'b0, 1'b0);
						n = n + 3'd1;
					end else if (ch == CH_EQ) begin
						pend_d = P_EQ;
					end else if (ch == CH_BANG) begin
						pend_d = P_BANG;
					end else if (ch == CH_LT) begin
						pend_d = P_LT;
					end else if (ch == CH_GT) begin
						pend_d = P_GT;
					end else begin
						res[n[1:0]] = mk(qtt_pkg::K_EMPTY, 8'h00, 1'b0, 1'b0);
						n = n + 3'd1;
					end
				end
			end

			// end of source: flush operator, open token, then the end marker
			if (ch == CH_NUL || last) begin
				if (pend_d != P_NONE) begin
					res[n[1:0]] = mk(op_alone(pend_d), 8'h00, 1'b0, 1'b0);
					n = n + 3'd1;
				end
				if (mode_d == M_IDENT) begin
					res[n[1:0]] = mk((kw_d == KW_AND) ? qtt_pkg::K_AND :
						((kw_d == KW_OR) ? qtt_pkg::K_OR : qtt_pkg::K_IDENT),
						8'h00, 1'b0, 1'b0);
					n = n + 3'd1;
				end else if (mode_d == M_NUMBER) begin
					res[n[1:0]] = mk(qtt_pkg::K_NUMBER, 8'h00, 1'b0, 1'b0);
					n = n + 3'd1;
				end else if (mode_d == M_STRING) begin
					if (esc_d) begin
						res[n[1:0]] = mk(qtt_pkg::K_STRING, CH_BSLASH, 1'b1, 1'b0);
						n = n + 3'd1;
					end
					res[n[1:0]] = mk(qtt_pkg::K_STRING, 8'h00, 1'b0, 1'b0);
					n = n + 3'd1;
				end
				res[n[1:0]] = mk(qtt_pkg::K_EMPTY, 8'h00, 1'b0, 1'b1);
				n = n + 3'd1;
				pend_d   = P_NONE;
				mode_d   = M_IDLE;
				kw_d     = KW_NONE;
				dquote_d = 1'b0;
				esc_d    = 1'b0;
				if (ch == CH_NUL && !last)
					ended_d = 1'b1;
			end
		end
	end

	assign batch.res = res;
	assign batch.n   = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pend_q   <= P_NONE;
			kw_q     <= KW_NONE;
			dquote_q <= 1'b0;
			esc_q    <= 1'b0;
			ended_q  <= 1'b0;
		end else if (step) begin
			mode_q   <= mode_d;
			pend_q   <= pend_d;
			kw_q     <= kw_d;
			dquote_q <= dquote_d;
			esc_q    <= esc_d;
			ended_q  <= ended_d;
		end
	end

endmodule

// File: rtl/qtt_out_buf.sv
module qtt_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  qtt_pkg::qtt_batch_t  batch,
	output logic                 free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output qtt_pkg::qtt_result_t out_res,
	output logic                 out_final
);

	qtt_pkg::qtt_result_t [qtt_pkg::MAX_RESULTS-1:0] slot_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign out_valid = cnt_q != 3'd0;
	assign pop       = out_valid && out_ready;
	// free when the next cycle finds no result left from the previous character
	assign free      = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_ready);
	assign out_res   = slot_q[0];
	assign out_final = cnt_q == 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= batch.n;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= batch.res;
		end else if (pop) begin
			for (int i = 0; i < qtt_pkg::MAX_RESULTS - 1; i++)
				slot_q[i] <= slot_q[i+1];
		end
	end

endmodule

// File: rtl/query_text_tokenizer.sv
// Channel  Dir  tdata                 tuser                                    tlast
// s_*      in   [7:0] ch              -                                        last
// m_*      out  [7:0] text_byte       [3:0] kind, [4] is_text, [5] source_end  run_last
//
// One character per cycle while each character gives at most one result and m_tready is high; a
// character with more results holds the input while they leave, one per cycle while m_tready is high.
// The first result of a character reaches m_* through the input register and then the result buffer.
// arst_n clears lexer state and the result buffer; no sweep after reset.
// A stalled m_tready backs up into s_tready through the input register.
`include "query_text_tokenizer_defines.svh"

module query_text_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] ch
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] text_byte
	output logic [7:0] m_tuser,  // [3:0] kind, [4] is_text, [5] source_end, [7:6] zero
	output logic       m_tlast
);

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	logic       buf_free;
	logic       step;

	qtt_pkg::qtt_batch_t  batch;
	qtt_pkg::qtt_result_t out_res;

	assign step     = valid_s1 && buf_free;
	assign s_tready = !valid_s1 || buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	qtt_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ch     (ch_s1),
		.last   (last_s1),
		.batch  (batch)
	);

	qtt_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.batch     (batch),
		.free      (buf_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res),
		.out_final (m_tlast)
	);

	assign m_tdata = out_res.is_text ? out_res.text_byte : 8'h00;
	assign m_tuser = {2'b00, out_res.source_end, out_res.is_text, out_res.kind};

	// a new batch never overwrites results still owed downstream
	`QTT_ASSERT_IMPLY(a_load_when_free, step,
		!m_tvalid || (m_tlast && m_tready))
	// the end marker is always the final result of its character
	`QTT_ASSERT_IMPLY(a_end_is_final, m_tvalid && out_res.source_end, m_tlast && !out_res.is_text)
	// text bytes only belong to identifiers, numbers and strings
	`QTT_ASSERT_IMPLY(a_text_kind, m_tvalid && out_res.is_text,
		out_res.kind == qtt_pkg::K_IDENT || out_res.kind == qtt_pkg::K_NUMBER ||
		out_res.kind == qtt_pkg::K_STRING)

endmodule
